// ----- design/ritm_pkg.sv -----
// Shared types and constants of the repeat/one-shot interval timer.
package ritm_pkg;

  localparam int TIME_BITS = 32;
  localparam int ID_BITS = 16;
  localparam int REM_W = TIME_BITS + 2;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_RESET = 3'd1;
  localparam logic [2:0] OP_FIRE = 3'd2;
  localparam logic [2:0] OP_TICK = 3'd3;
  localparam logic [2:0] OP_SET_ENABLE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_KEEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_FIRE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID = 3'd5;

  localparam logic ALU_SUB = 1'b1;
  localparam logic ALU_ADD = 1'b0;

  typedef struct packed {
    logic [2:0] op;
    logic [TIME_BITS-1:0] delta;
    logic [ID_BITS-1:0] activator;
    logic enable_value;
  } in_item_t;

  typedef struct packed {
    logic [ID_BITS-1:0] event_activator;
    logic last;
  } out_item_t;

endpackage

// ----- design/repeat_oneshot_interval_timer_core.sv -----
// Top level of the repeat/one-shot interval timer: sequencer, state and output register.
//
// Commands arrive as items on the in channel (valid/ready): start, reset, fire,
// tick and set enable. Events leave as items on the out channel, each with the
// activator id and a last flag on the final event caused by one command.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// A command is taken while idle and executed in the cycle after; reset and set
// enable finish there, as does start unless it fires. An armed tick with a nonzero
// delta then subtracts in the shared adder and, if the timer is due and enabled,
// produces one event per cycle while the receiver does not stall, up to MAX_CATCHUP,
// each reload from the same adder; in_ready is high only while the sequencer is idle.
// The finished event sits in an output register, so the next command can be
// taken while it waits. When the receiver stalls the sequencer holds before
// writing the next event and resumes as the register is emptied.
// Synchronous reset loads the register defaults, clears the remaining count
// and the armed flag, sets the enable and empties the output register.
module repeat_oneshot_interval_timer_core #(
  parameter int MAX_CATCHUP = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ritm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ritm_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ritm_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ritm_pkg::out_item_t                 out_item
);

  localparam int CNT_W = $clog2(MAX_CATCHUP + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CATCHUP);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SUB = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [ritm_pkg::TIME_BITS-1:0] first_delay;
  logic [ritm_pkg::TIME_BITS-1:0] interval;
  logic repeat_mode;
  logic start_keep;
  logic start_fire;
  logic [ritm_pkg::ID_BITS-1:0] own_id;

  logic [1:0] state;
  logic signed [ritm_pkg::REM_W-1:0] remaining;
  logic enabled;
  logic armed;
  ritm_pkg::in_item_t cmd;
  logic single;
  logic [ritm_pkg::ID_BITS-1:0] who;
  logic [CNT_W-1:0] cnt;

  logic alu_mode;
  logic [ritm_pkg::TIME_BITS-1:0] alu_operand;
  logic signed [ritm_pkg::REM_W-1:0] alu_result;
  logic signed [ritm_pkg::REM_W-1:0] load_value;
  logic slot_free;
  logic signed [ritm_pkg::REM_W-1:0] rem_next;
  logic enabled_next;
  logic last_next;
  logic start_en;

  assign alu_mode = (state == ST_SUB) ? ritm_pkg::ALU_SUB : ritm_pkg::ALU_ADD;
  assign alu_operand = (state == ST_SUB) ? cmd.delta : interval;

  ritm_alu u_alu (
    .mode    (alu_mode),
    .rem     (remaining),
    .operand (alu_operand),
    .result  (alu_result)
  );

  assign load_value = (first_delay != '0) ? $signed({2'b00, first_delay})
                                          : $signed({2'b00, interval});
  assign slot_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign start_en = enabled && start_keep;

  always_comb begin
    if (single) begin
      rem_next = repeat_mode ? $signed({2'b00, interval}) : remaining;
      enabled_next = repeat_mode ? enabled : 1'b0;
      last_next = 1'b1;
    end else begin
      rem_next = repeat_mode ? alu_result : remaining;
      enabled_next = repeat_mode ? enabled : 1'b0;
      last_next = !((rem_next[ritm_pkg::REM_W-1] || rem_next == '0) && enabled_next &&
                    ((cnt + 1'b1) < CNT_MAX));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay <= '0;
      interval <= '0;
      repeat_mode <= 1'b1;
      start_keep <= 1'b1;
      start_fire <= 1'b0;
      own_id <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ritm_pkg::REG_FIRST_DELAY: first_delay <= cfg_data[ritm_pkg::TIME_BITS-1:0];
        ritm_pkg::REG_INTERVAL: interval <= cfg_data[ritm_pkg::TIME_BITS-1:0];
        ritm_pkg::REG_REPEAT_MODE: repeat_mode <= cfg_data[0];
        ritm_pkg::REG_START_KEEP: start_keep <= cfg_data[0];
        ritm_pkg::REG_START_FIRE: start_fire <= cfg_data[0];
        ritm_pkg::REG_OWN_ID: own_id <= cfg_data[ritm_pkg::ID_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      remaining <= '0;
      enabled <= 1'b1;
      armed <= 1'b0;
      out_valid <= 1'b0;
      single <= 1'b0;
      cnt <= '0;
    end else begin
      if (state == ST_EMIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd <= in_item;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          single <= 1'b1;
          cnt <= '0;
          case (cmd.op)
            ritm_pkg::OP_START: begin
              remaining <= load_value;
              armed <= 1'b1;
              enabled <= start_en;
              who <= own_id;
              if (start_fire && start_en) begin
                state <= ST_EMIT;
              end
            end
            ritm_pkg::OP_RESET: remaining <= load_value;
            ritm_pkg::OP_FIRE: begin
              who <= cmd.activator;
              state <= ST_EMIT;
            end
            ritm_pkg::OP_TICK: begin
              if (armed && cmd.delta != '0) begin
                state <= ST_SUB;
              end
            end
            ritm_pkg::OP_SET_ENABLE: enabled <= cmd.enable_value;
            default: ;
          endcase
        end
        ST_SUB: begin
          remaining <= alu_result;
          single <= 1'b0;
          who <= own_id;
          if ((alu_result[ritm_pkg::REM_W-1] || alu_result == '0) && enabled) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_item.event_activator <= who;
            out_item.last <= last_next;
            remaining <= rem_next;
            enabled <= enabled_next;
            cnt <= cnt + 1'b1;
            if (last_next) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/ritm_alu.sv -----
// Shared add/subtract unit with floor saturation or zero clamp on the remaining count.
module ritm_alu (
  input  logic                             mode,
  input  logic signed [ritm_pkg::REM_W-1:0] rem,
  input  logic [ritm_pkg::TIME_BITS-1:0]   operand,
  output logic signed [ritm_pkg::REM_W-1:0] result
);

  localparam int SW = ritm_pkg::REM_W + 1;

  logic signed [SW-1:0] rem_ext;
  logic signed [SW-1:0] opd_ext;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] floor_val;

  assign rem_ext = {rem[ritm_pkg::REM_W-1], rem};
  assign opd_ext = $signed({3'b000, operand});
  assign floor_val = $signed({2'b11, {(SW-2){1'b0}}});

  always_comb begin
    if (mode == ritm_pkg::ALU_SUB) begin
      sum = rem_ext - opd_ext;
      if (sum < floor_val) begin
        result = floor_val[ritm_pkg::REM_W-1:0];
      end else begin
        result = sum[ritm_pkg::REM_W-1:0];
      end
    end else begin
      sum = rem_ext + opd_ext;
      if (sum[SW-1]) begin
        result = '0;
      end else begin
        result = sum[ritm_pkg::REM_W-1:0];
      end
    end
  end

endmodule

// ----- tb/timer_event_checker.sv -----
// Checker for the interval timer: predicts the events of every command item and compares them.
module timer_event_checker #(
  parameter int MAX_CATCHUP = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ritm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ritm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  ritm_pkg::in_item_t             in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  ritm_pkg::out_item_t            out_item,
  output int                             mismatch_count,
  output int                             events_pending
);
  import ritm_pkg::*;

  localparam longint REM_FLOOR = -(longint'(1) << (TIME_BITS + 1));
  localparam int PRINT_LIMIT = 100;

  logic [TIME_BITS-1:0] first_delay_cfg;
  logic [TIME_BITS-1:0] interval_cfg;
  logic repeat_cfg;
  logic start_en_cfg;
  logic fire_start_cfg;
  logic [ID_BITS-1:0] own_id_cfg;

  logic signed [REM_W-1:0] remaining_ticks;
  logic timer_enabled;
  logic timer_armed;

  logic [ID_BITS-1:0] fired_ids[$];
  out_item_t expected_events[$];
  out_item_t want;

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] timer mismatch: %s", $time, what);
    end
    mismatch_count = mismatch_count + 1;
  endtask

  function automatic logic signed [REM_W-1:0] load_ticks();
    if (first_delay_cfg != '0) begin
      return $signed({2'b00, first_delay_cfg});
    end
    return $signed({2'b00, interval_cfg});
  endfunction

  task automatic fire_event(input logic [ID_BITS-1:0] who);
    fired_ids.push_back(who);
    if (repeat_cfg) begin
      remaining_ticks = $signed({2'b00, interval_cfg});
    end else begin
      timer_enabled = 1'b0;
    end
  endtask

  task automatic predict_events(input in_item_t cmd);
    longint level;
    longint overshoot;
    longint next_level;
    out_item_t ev;
    fired_ids.delete();
    case (cmd.op)
      OP_START: begin
        remaining_ticks = load_ticks();
        timer_armed = 1'b1;
        if (!start_en_cfg) begin
          timer_enabled = 1'b0;
        end
        if (fire_start_cfg && timer_enabled) begin
          fire_event(own_id_cfg);
        end
      end
      OP_RESET: begin
        remaining_ticks = load_ticks();
      end
      OP_FIRE: begin
        fire_event(cmd.activator);
      end
      OP_TICK: begin
        if (timer_armed && cmd.delta != '0) begin
          level = longint'(remaining_ticks) - longint'(cmd.delta);
          if (level < REM_FLOOR) begin
            level = REM_FLOOR;
          end
          while (level <= 0 && timer_enabled && fired_ids.size() < MAX_CATCHUP) begin
            overshoot = -level;
            fire_event(own_id_cfg);
            if (repeat_cfg && timer_enabled) begin
              next_level = longint'(interval_cfg) - overshoot;
              level = (next_level > 0) ? next_level : 0;
            end
          end
          remaining_ticks = REM_W'(level);
        end
      end
      OP_SET_ENABLE: begin
        timer_enabled = cmd.enable_value;
      end
      default: begin
      end
    endcase
    for (int k = 0; k < fired_ids.size(); k++) begin
      ev.event_activator = fired_ids[k];
      ev.last = (k == fired_ids.size() - 1);
      expected_events.push_back(ev);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      first_delay_cfg = '0;
      interval_cfg = '0;
      repeat_cfg = 1'b1;
      start_en_cfg = 1'b1;
      fire_start_cfg = 1'b0;
      own_id_cfg = '0;
      remaining_ticks = '0;
      timer_enabled = 1'b1;
      timer_armed = 1'b0;
      expected_events.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FIRST_DELAY: first_delay_cfg = cfg_data[TIME_BITS-1:0];
          REG_INTERVAL: interval_cfg = cfg_data[TIME_BITS-1:0];
          REG_REPEAT_MODE: repeat_cfg = cfg_data[0];
          REG_START_KEEP: start_en_cfg = cfg_data[0];
          REG_START_FIRE: fire_start_cfg = cfg_data[0];
          REG_OWN_ID: own_id_cfg = cfg_data[ID_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        predict_events(in_item);
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event, activator %h last %b",
                                    out_item.event_activator, out_item.last));
        end else begin
          want = expected_events.pop_front();
          if (out_item.event_activator !== want.event_activator) begin
            report_mismatch($sformatf("activator %h, predicted %h",
                                      out_item.event_activator, want.event_activator));
          end
          if (out_item.last !== want.last) begin
            report_mismatch($sformatf("last flag %b, predicted %b", out_item.last, want.last));
          end
        end
      end
    end
    events_pending <= expected_events.size();
  end

endmodule

// ----- tb/repeat_oneshot_interval_timer_core_test.sv -----
// Top of the interval timer testbench: clock, reset, command and stall stimulus, verdict.
module repeat_oneshot_interval_timer_core_test;
  import ritm_pkg::*;

  localparam int MAX_CATCHUP = 16;
  localparam int SETTLE_CYCLES = MAX_CATCHUP + 6;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 20;
  localparam longint RUN_LIMIT = 5_000_000;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  int mismatch_count;
  int events_pending;
  int burst_left = 0;
  logic [15:0] ready_mask = 16'hFFFF;
  int mask_age = 0;

  repeat_oneshot_interval_timer_core #(
    .MAX_CATCHUP(MAX_CATCHUP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  timer_event_checker #(
    .MAX_CATCHUP(MAX_CATCHUP)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .mismatch_count(mismatch_count),
    .events_pending(events_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

  function automatic logic [15:0] next_ready_mask();
    case ($urandom_range(0, 3))
      0: return 16'hFFFF;
      1: return 16'd1 << $urandom_range(0, 15);
      default: return 16'($urandom_range(1, 16'hFFFF));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_mask <= 16'hFFFF;
      mask_age <= 0;
    end else begin
      out_ready <= ready_mask[0];
      if (mask_age == 63) begin
        ready_mask <= next_ready_mask();
        mask_age <= 0;
      end else begin
        ready_mask <= {ready_mask[0], ready_mask[15:1]};
        mask_age <= mask_age + 1;
      end
    end
  end

  function automatic in_item_t make_cmd(input logic [2:0] op, input logic [TIME_BITS-1:0] delta,
                                        input logic [ID_BITS-1:0] who, input logic en);
    in_item_t cmd;
    cmd.op = op;
    cmd.delta = delta;
    cmd.activator = who;
    cmd.enable_value = en;
    return cmd;
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_ticks(input int span);
    case ($urandom_range(0, 19))
      0, 1: return '0;
      2: return '1;
      3, 4: return $urandom();
      default: return TIME_BITS'($urandom_range(1, span));
    endcase
  endfunction

  function automatic in_item_t random_cmd();
    int roll;
    logic [2:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      op = OP_TICK;
    end else if (roll < 55) begin
      op = OP_START;
    end else if (roll < 63) begin
      op = OP_RESET;
    end else if (roll < 73) begin
      op = OP_FIRE;
    end else if (roll < 90) begin
      op = OP_SET_ENABLE;
    end else begin
      op = 3'(OP_SET_ENABLE + $urandom_range(1, 3));
    end
    return make_cmd(op, pick_ticks(40), ID_BITS'($urandom()), $urandom_range(0, 3) != 0);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic program_timer(input logic [TIME_BITS-1:0] first_delay,
                               input logic [TIME_BITS-1:0] interval, input logic repeat_on,
                               input logic start_en, input logic fire_start,
                               input logic [ID_BITS-1:0] own_id);
    write_reg(REG_FIRST_DELAY, CFG_W'(first_delay));
    write_reg(REG_INTERVAL, CFG_W'(interval));
    write_reg(REG_REPEAT_MODE, CFG_W'(repeat_on));
    write_reg(REG_START_KEEP, CFG_W'(start_en));
    write_reg(REG_START_FIRE, CFG_W'(fire_start));
    write_reg(REG_OWN_ID, CFG_W'(own_id));
    cfg_we <= 1'b0;
  endtask

  task automatic send_cmd(input in_item_t cmd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left = burst_left - 1;
    in_item <= cmd;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int counted;
    in_item_t cmd;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_timer(32'd5, 32'd3, 1'b1, 1'b1, 1'b1, 16'hFFFF);
    send_cmd(make_cmd(OP_TICK, 32'd10, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_RESET, 32'd0, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_FIRE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    send_cmd(make_cmd(OP_FIRE, 32'd0, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_START, 32'd0, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_TICK, 32'd0, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_TICK, 32'd4, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    send_cmd(make_cmd(OP_SET_ENABLE, 32'd0, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_TICK, 32'd50, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_SET_ENABLE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1));
    send_cmd(make_cmd(OP_TICK, 32'd1, 16'h0000, 1'b0));
    for (int k = 1; k <= 3; k++) begin
      send_cmd(make_cmd(3'(OP_SET_ENABLE + k), 32'd1, 16'h1111, 1'b1));
    end
    drain();

    // One-shot mode with start clearing the enable, so the start does not fire.
    program_timer(32'd0, 32'd0, 1'b0, 1'b0, 1'b1, 16'h0000);
    send_cmd(make_cmd(OP_START, 32'd0, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_SET_ENABLE, 32'd0, 16'h0000, 1'b1));
    send_cmd(make_cmd(OP_TICK, 32'd1, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_FIRE, 32'd0, 16'h8001, 1'b0));
    send_cmd(make_cmd(OP_TICK, 32'd5, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_SET_ENABLE, 32'd0, 16'h0000, 1'b1));
    send_cmd(make_cmd(OP_TICK, 32'd1, 16'h0000, 1'b0));
    drain();

    // A zero interval in periodic mode runs the full catch-up.
    program_timer(32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 16'h5A5A);
    send_cmd(make_cmd(OP_START, 32'd0, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_TICK, 32'd1, 16'h0000, 1'b0));
    drain();

    program_timer('1, '1, 1'b1, 1'b1, 1'b0, 16'h1234);
    send_cmd(make_cmd(OP_START, 32'd0, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_TICK, 32'hFFFF_FFFF, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_TICK, 32'hFFFF_FFFE, 16'h0000, 1'b0));
    send_cmd(make_cmd(OP_RESET, 32'd0, 16'h0000, 1'b0));
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      program_timer(pick_ticks(30), pick_ticks(20), $urandom_range(0, 2) != 0,
                    $urandom_range(0, 4) != 0, $urandom_range(0, 1),
                    ID_BITS'($urandom()));
      counted = 0;
      if ($urandom_range(0, 4) != 0) begin
        send_cmd(make_cmd(OP_START, pick_ticks(40), ID_BITS'($urandom()), 1'b1));
        counted = 1;
      end
      while (counted < ITEMS_PER_PHASE) begin
        cmd = random_cmd();
        send_cmd(cmd);
        if (cmd.op <= OP_SET_ENABLE) begin
          counted = counted + 1;
        end
      end
      drain();
    end

    if (mismatch_count == 0 && events_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ritm_pkg.sv
design/ritm_alu.sv
design/repeat_oneshot_interval_timer_core.sv
tb/timer_event_checker.sv
tb/repeat_oneshot_interval_timer_core_test.sv
